>>> hdl/hcpf_pkg.sv
// ----------------------------------------------------------------------------
// hcpf_pkg
// Shared types and constants of the harmonic cut pair force block.
// ----------------------------------------------------------------------------
package hcpf_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int FK_SHIFT        = 15;

    localparam logic [1:0] CFG_SPRING = 2'd0;
    localparam logic [1:0] CFG_CUTOFF = 2'd1;

    typedef struct packed {
        logic signed [23:0] del_x;
        logic signed [23:0] del_y;
        logic signed [23:0] del_z;
        logic [15:0]        special_factor;
        logic               last_neighbor;
    } t_in;

    typedef struct packed {
        logic signed [39:0] force_x;
        logic signed [39:0] force_y;
        logic signed [39:0] force_z;
        logic [38:0]        force_over_r;
        logic [39:0]        pair_energy;
        logic               in_range;
        logic signed [47:0] total_x;
        logic signed [47:0] total_y;
        logic signed [47:0] total_z;
        logic               center_done;
    } t_out;

    typedef struct packed {
        logic [2:0][23:0] mag;
        logic [2:0]       neg;
        logic [15:0]      factor;
        logic             last;
        logic             in_range;
        logic [47:0]      rsq;
    } t_job;

endpackage

>>> hdl/hcpf_queue.sv
// ----------------------------------------------------------------------------
// hcpf_queue
// Two-entry job queue between the front classifier and the back sequencer.
// ----------------------------------------------------------------------------
module hcpf_queue
    import hcpf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

>>> hdl/hcpf_front.sv
// ----------------------------------------------------------------------------
// hcpf_front
// Accept a neighbour transaction, square the displacements and classify
// the pair against the squared cutoff.
// ----------------------------------------------------------------------------
module hcpf_front
    import hcpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_data,
    input  logic [45:0] i_cut_sq,
    output logic        o_push,
    output t_job        o_job,
    input  logic        i_full
);

    logic             r_valid;
    logic [2:0][23:0] r_mag;
    logic [2:0]       r_neg;
    logic [15:0]      r_factor;
    logic             r_last;
    logic [2:0][47:0] r_sq;

    logic [2:0][23:0] n_mag;
    logic [2:0]       n_neg;
    logic [47:0]      rsq;

    always_comb begin
        n_neg[0] = i_data.del_x[23];
        n_neg[1] = i_data.del_y[23];
        n_neg[2] = i_data.del_z[23];
        n_mag[0] = n_neg[0] ? 24'(-i_data.del_x) : i_data.del_x;
        n_mag[1] = n_neg[1] ? 24'(-i_data.del_y) : i_data.del_y;
        n_mag[2] = n_neg[2] ? 24'(-i_data.del_z) : i_data.del_z;
    end

    assign o_push  = r_valid && !i_full;
    assign o_ready = !r_valid || !i_full;
    assign rsq     = r_sq[0] + r_sq[1] + r_sq[2];

    always_comb begin
        o_job.mag      = r_mag;
        o_job.neg      = r_neg;
        o_job.factor   = r_factor;
        o_job.last     = r_last;
        o_job.rsq      = rsq;
        o_job.in_range = (rsq < {2'b00, i_cut_sq});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_mag    <= n_mag;
            r_neg    <= n_neg;
            r_factor <= i_data.special_factor;
            r_last   <= i_data.last_neighbor;
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= n_mag[i] * n_mag[i];
            end
        end
    end

endmodule

>>> hdl/hcpf_back.sv
// ----------------------------------------------------------------------------
// hcpf_back
// Sequencer: square root, energy, force/r division, force components,
// saturating per-centre sums and the output register.
// ----------------------------------------------------------------------------
module hcpf_back
    import hcpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_job        i_job,
    output logic        o_pop,
    input  logic [31:0] i_spring,
    input  logic [22:0] i_cutoff,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_SQRT, S_FK, S_P, S_ELO, S_EHI, S_ESAT, S_DIV,
        S_CLO, S_CHI, S_CSAT, S_SUM, S_OUT
    } t_state;

    localparam logic [38:0] FOVR_MAX = '1;

    t_state             r_state;
    t_job               r_job;
    logic [47:0]        r_sv;
    logic [47:0]        r_res;
    logic [47:0]        r_bit;
    logic [22:0]        r_delta;
    logic [32:0]        r_fk;
    logic [55:0]        r_p;
    logic [81:0]        r_acc;
    logic [39:0]        r_energy;
    logic [38:0]        r_fovr;
    logic [56:0]        r_quo;
    logic [23:0]        r_rem;
    logic [5:0]         r_dcnt;
    logic [1:0]         r_comp;
    logic signed [39:0] r_f [3];
    logic signed [47:0] r_sum [3];
    logic signed [47:0] r_tot [3];
    logic               r_out_valid;
    t_out               r_out;

    logic [32:0]        mul_a;
    logic [23:0]        mul_b;
    logic [56:0]        mul_p;
    logic [47:0]        sq_try;
    logic [23:0]        div_t;
    logic [81:0]        e_sh;
    logic [81:0]        c_sh;
    logic [39:0]        c_mag;
    logic signed [47:0] n_sum [3];
    logic signed [48:0] add_t [3];

    assign o_pop   = (r_state == S_IDLE) && i_q_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_FK: begin
                mul_a = {1'b0, i_spring};
                mul_b = {8'b0, r_job.factor};
            end
            S_P: begin
                mul_a = r_fk;
                mul_b = {1'b0, r_delta};
            end
            S_ELO: begin
                mul_a = {5'b0, r_p[27:0]};
                mul_b = {1'b0, r_delta};
            end
            S_EHI: begin
                mul_a = {5'b0, r_p[55:28]};
                mul_b = {1'b0, r_delta};
            end
            S_CLO: begin
                mul_a = {4'b0, r_quo[28:0]};
                mul_b = r_job.mag[r_comp];
            end
            S_CHI: begin
                mul_a = {5'b0, r_quo[56:29]};
                mul_b = r_job.mag[r_comp];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p  = mul_a * mul_b;
    assign sq_try = r_res + r_bit;
    assign div_t  = {r_rem[22:0], r_quo[56]};
    assign e_sh   = r_acc >> (2 * COORD_FRAC_BITS);
    assign c_sh   = r_acc >> COORD_FRAC_BITS;

    always_comb begin
        if (r_job.neg[r_comp]) begin
            if ((|c_sh[81:40]) || (c_sh[39] && (|c_sh[38:0]))) begin
                c_mag = 40'h80_0000_0000;
            end else begin
                c_mag = c_sh[39:0];
            end
        end else begin
            if (|c_sh[81:39]) begin
                c_mag = {1'b0, FOVR_MAX};
            end else begin
                c_mag = c_sh[39:0];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            add_t[i] = {r_sum[i][47], r_sum[i]} + 49'(r_f[i]);
            if (add_t[i][48] != add_t[i][47]) begin
                n_sum[i] = add_t[i][48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
            end else begin
                n_sum[i] = add_t[i][47:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_sum[i] <= '0;
            end
        end else begin
            if (r_out_valid && i_ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_job    <= i_job;
                        r_sv     <= i_job.rsq;
                        r_res    <= '0;
                        r_bit    <= 48'h1 << 46;
                        r_energy <= '0;
                        r_fovr   <= '0;
                        for (int i = 0; i < 3; i++) begin
                            r_f[i] <= '0;
                        end
                        r_state  <= i_job.in_range ? S_SQRT : S_SUM;
                    end
                end
                S_SQRT: begin
                    if (r_sv >= sq_try) begin
                        r_sv  <= r_sv - sq_try;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_state <= S_FK;
                    end
                end
                S_FK: begin
                    r_delta <= i_cutoff - r_res[22:0];
                    r_fk    <= mul_p[47:FK_SHIFT];
                    r_state <= S_P;
                end
                S_P: begin
                    r_p     <= mul_p[55:0];
                    r_state <= S_ELO;
                end
                S_ELO: begin
                    r_acc   <= 82'(mul_p);
                    r_state <= S_EHI;
                end
                S_EHI: begin
                    r_acc   <= r_acc + (82'(mul_p) << 28);
                    r_state <= S_ESAT;
                end
                S_ESAT: begin
                    r_energy <= (|e_sh[81:40]) ? '1 : e_sh[39:0];
                    if (r_res[22:0] == '0) begin
                        r_fovr  <= FOVR_MAX;
                        r_state <= S_SUM;
                    end else begin
                        r_quo   <= {r_p, 1'b0};
                        r_rem   <= '0;
                        r_dcnt  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_t >= {1'b0, r_res[22:0]}) begin
                        r_rem <= div_t - {1'b0, r_res[22:0]};
                        r_quo <= {r_quo[55:0], 1'b1};
                    end else begin
                        r_rem <= div_t;
                        r_quo <= {r_quo[55:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt + 6'd1;
                    if (r_dcnt == 6'd56) begin
                        r_comp  <= 2'd0;
                        r_state <= S_CLO;
                    end
                end
                S_CLO: begin
                    r_fovr  <= (|r_quo[56:39]) ? FOVR_MAX : r_quo[38:0];
                    r_acc   <= 82'(mul_p);
                    r_state <= S_CHI;
                end
                S_CHI: begin
                    r_acc   <= r_acc + (82'(mul_p) << 29);
                    r_state <= S_CSAT;
                end
                S_CSAT: begin
                    r_f[r_comp] <= r_job.neg[r_comp] ? -c_mag : c_mag;
                    if (r_comp == 2'd2) begin
                        r_state <= S_SUM;
                    end else begin
                        r_comp  <= r_comp + 2'd1;
                        r_state <= S_CLO;
                    end
                end
                S_SUM: begin
                    for (int i = 0; i < 3; i++) begin
                        r_tot[i] <= r_job.last ? n_sum[i] : '0;
                        r_sum[i] <= r_job.last ? '0 : n_sum[i];
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid        <= 1'b1;
                        r_out.force_x      <= r_f[0];
                        r_out.force_y      <= r_f[1];
                        r_out.force_z      <= r_f[2];
                        r_out.force_over_r <= r_fovr;
                        r_out.pair_energy  <= r_energy;
                        r_out.in_range     <= r_job.in_range;
                        r_out.total_x      <= r_tot[0];
                        r_out.total_y      <= r_tot[1];
                        r_out.total_z      <= r_tot[2];
                        r_out.center_done  <= r_job.last;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && (!r_out_valid || i_ready)) |=> r_out_valid)
        else $error("result not loaded into output register");

    a_sum_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM && r_job.last) |=>
        (r_sum[0] == '0 && r_sum[1] == '0 && r_sum[2] == '0))
        else $error("sums not cleared after last neighbour");

    a_out_of_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM && !r_job.in_range) |->
        (r_f[0] == '0 && r_f[1] == '0 && r_f[2] == '0 && r_energy == '0 && r_fovr == '0))
        else $error("out of range pair carries non-zero result");

    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dcnt <= 6'd56))
        else $error("divider ran past its last step");

endmodule

>>> hdl/harmonic_cut_pair_force.sv
// ----------------------------------------------------------------------------
// harmonic_cut_pair_force
// Harmonic repulsive pair force over a stream of neighbour transactions.
// ----------------------------------------------------------------------------
// The front accepts one neighbour per cycle into a two-entry queue while it
// has room, but sustained throughput is set by the back sequencer: for a
// pair inside the cutoff it runs 24 square root steps, 57 restoring division
// steps, 10 steps on one shared 33x24 multiplier, take-up, saturation,
// summing and output; for coincident atoms it skips the division and force
// steps, for a pair outside it does only take-up, summing and output, and it
// waits on a stalled receiver. Write spring_constant (index 0) and
// cutoff_distance (index 1) only while no transaction is in flight.
// ----------------------------------------------------------------------------
module harmonic_cut_pair_force
    import hcpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [31:0] r_spring;
    logic [22:0] r_cutoff;
    logic [45:0] r_cut_sq;

    logic        push;
    logic        full;
    logic        pop;
    logic        q_valid;
    t_job        f_job;
    t_job        q_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spring <= '0;
            r_cutoff <= '0;
            r_cut_sq <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_SPRING) begin
                r_spring <= i_cfg_data;
            end else if (i_cfg_index == CFG_CUTOFF) begin
                r_cutoff <= i_cfg_data[22:0];
                r_cut_sq <= i_cfg_data[22:0] * i_cfg_data[22:0];
            end
        end
    end

    hcpf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_data   (i_in_data),
        .i_cut_sq (r_cut_sq),
        .o_push   (push),
        .o_job    (f_job),
        .i_full   (full)
    );

    hcpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    hcpf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (q_job),
        .o_pop     (pop),
        .i_spring  (r_spring),
        .i_cutoff  (r_cutoff),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_data    (o_out_data)
    );

endmodule
